>>> rtl/core/hamming_ellipse_point_count_unit_defines.svh
// Assertion macros for the point counter RTL.
`ifndef HAMMING_ELLIPSE_POINT_COUNT_UNIT_DEFINES_SVH
`define HAMMING_ELLIPSE_POINT_COUNT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HEPC_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define HEPC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define HEPC_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg)
`define HEPC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif

`endif

>>> rtl/core/hepc_pkg.sv
`timescale 1ns / 1ps
package hepc_pkg;

    localparam int MAX_LEN_DEFAULT = 64;
    localparam int Q_W = 9;
    localparam int D_W = 8;
    localparam int SYM_W = 8;
    localparam int COUNT_W = 64;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [Q_W-1:0] ALPHABET_RESET = 9'd2;
    localparam logic [D_W-1:0] TARGET_RESET = 8'd0;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_TARGET = 2'd1,
        STATUS_LONG   = 2'd2
    } status_t;

    typedef enum logic {
        REG_ALPHABET = 1'b0,
        REG_TARGET   = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic issue;
        logic same;
    } mac_ctl_t;

    typedef struct packed {
        logic set;
        logic clear;
    } fill_ctl_t;

endpackage

>>> rtl/core/hepc_in_if.sv
`timescale 1ns / 1ps
interface hepc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sym_first;
    logic [7:0] sym_second;
    logic       last_position;

    modport source (output valid, sym_first, sym_second, last_position, input ready);
    modport sink (input valid, sym_first, sym_second, last_position, output ready);
endinterface

>>> rtl/core/hepc_out_if.sv
`timescale 1ns / 1ps
interface hepc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] point_count;
    logic [1:0]  status;

    modport source (output valid, point_count, status, input ready);
    modport sink (input valid, point_count, status, output ready);
endinterface

>>> rtl/core/hepc_table.sv
`timescale 1ns / 1ps
module hepc_table
    import hepc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rd_en,
    input  logic [$clog2(2*MAX_LEN+1)-1:0]        rd_addr,
    output logic [COUNT_W-1:0]                    rd_data,
    input  logic                                  wr_en,
    input  logic [$clog2(2*MAX_LEN+1)-1:0]        wr_addr,
    input  logic [COUNT_W-1:0]                    wr_data,
    input  fill_ctl_t                             fill,
    input  logic [$clog2(2*MAX_LEN+2)-1:0]        fill_value
);

    localparam int TABLE_LEN = 2 * MAX_LEN + 1;
    localparam int FILL_W = $clog2(TABLE_LEN + 1);

    logic [COUNT_W-1:0] mem [TABLE_LEN];
    logic [COUNT_W-1:0] q_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               hit_reg;
    logic               zero_reg;

    // Entries at or above the fill count read as an empty table: one at entry 0, zero elsewhere.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            hit_reg  <= 1'b0;
            zero_reg <= 1'b0;
        end
        else
        begin
            if (fill.clear)
            begin
                fill_reg <= '0;
            end
            else if (fill.set)
            begin
                fill_reg <= fill_value;
            end
            if (rd_en)
            begin
                hit_reg  <= FILL_W'(rd_addr) < fill_reg;
                zero_reg <= rd_addr == '0;
            end
        end
    end

    assign rd_data = hit_reg ? q_reg : {{(COUNT_W-1){1'b0}}, zero_reg};

endmodule

>>> rtl/core/hepc_mac.sv
`timescale 1ns / 1ps
module hepc_mac
    import hepc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [Q_W-1:0]                        alphabet,
    input  mac_ctl_t                              mac_ctl,
    input  logic [$clog2(2*MAX_LEN+1)-1:0]        issue_addr,
    input  logic [COUNT_W-1:0]                    rd_data,
    output logic                                  wr_en,
    output logic [$clog2(2*MAX_LEN+1)-1:0]        wr_addr,
    output logic [COUNT_W-1:0]                    wr_data
);

    localparam int ADDR_W = $clog2(2 * MAX_LEN + 1);

    logic               s1_valid_reg;
    logic               s1_same_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic               s2_valid_reg;
    logic [ADDR_W-1:0]  s2_addr_reg;
    logic [COUNT_W-1:0] prod_reg;
    logic [COUNT_W-1:0] sub_reg;
    logic [COUNT_W-1:0] add_reg;
    logic [COUNT_W-1:0] p1_reg;
    logic [COUNT_W-1:0] p2_reg;
    logic               first;

    assign first = s1_addr_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= mac_ctl.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // The factor q-1 or q-2 is applied as q*m minus m or 2m, so that a
    // small alphabet wraps the same way as a 64-bit factor would.
    always_ff @(posedge clk)
    begin
        if (mac_ctl.issue)
        begin
            s1_same_reg <= mac_ctl.same;
            s1_addr_reg <= issue_addr;
        end
        if (s1_valid_reg)
        begin
            s2_addr_reg <= s1_addr_reg;
            prod_reg    <= rd_data * COUNT_W'(alphabet);
            sub_reg     <= s1_same_reg ? rd_data : {rd_data[COUNT_W-2:0], 1'b0};
            if (first)
            begin
                add_reg <= '0;
            end
            else
            begin
                add_reg <= s1_same_reg ? p2_reg : {p1_reg[COUNT_W-2:0], 1'b0};
            end
            p1_reg <= rd_data;
            p2_reg <= first ? '0 : p1_reg;
        end
    end

    assign wr_en   = s2_valid_reg;
    assign wr_addr = s2_addr_reg;
    assign wr_data = prod_reg - sub_reg + add_reg;

endmodule

>>> rtl/core/hepc_ctrl.sv
`timescale 1ns / 1ps
`include "hamming_ellipse_point_count_unit_defines.svh"
module hepc_ctrl
    import hepc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    hepc_in_if.sink                               item,
    hepc_out_if.source                            result,
    input  logic [D_W-1:0]                        target,
    output mac_ctl_t                              mac_ctl,
    output logic                                  rd_en,
    output logic [$clog2(2*MAX_LEN+1)-1:0]        rd_addr,
    input  logic [COUNT_W-1:0]                    rd_data,
    output fill_ctl_t                             fill,
    output logic [$clog2(2*MAX_LEN+2)-1:0]        fill_value
);

    localparam int ADDR_W = $clog2(2 * MAX_LEN + 1);
    localparam int FILL_W = $clog2(2 * MAX_LEN + 2);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int CMP_W = (LEN_W + 1 > D_W) ? LEN_W + 1 : D_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PASS   = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_READ   = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  j_reg, j_next;
    logic [ADDR_W-1:0]  top_reg, top_next;
    logic               same_reg, same_next;
    logic               last_reg, last_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic               ovf_reg, ovf_next;
    logic               drain_reg, drain_next;
    status_t            status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    status_t            out_status_reg, out_status_next;

    logic [LEN_W-1:0]   pos_inc;
    logic [CMP_W-1:0]   twice_pos;
    logic [CMP_W-1:0]   target_ext;
    logic               load_out;

    assign pos_inc    = pos_reg + LEN_W'(1);
    assign twice_pos  = CMP_W'({pos_reg, 1'b0});
    assign target_ext = CMP_W'(target);
    assign load_out   = (state_reg == S_RESULT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next      = state_reg;
        j_next          = j_reg;
        top_next        = top_reg;
        same_next       = same_reg;
        last_next       = last_reg;
        pos_next        = pos_reg;
        ovf_next        = ovf_reg;
        drain_next      = drain_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        mac_ctl.issue   = 1'b0;
        mac_ctl.same    = same_reg;
        rd_en           = 1'b0;
        rd_addr         = j_reg;
        fill.set        = 1'b0;
        fill.clear      = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    same_next = item.sym_first == item.sym_second;
                    last_next = item.last_position;
                    if (!ovf_reg && (pos_reg < LEN_W'(MAX_LEN)))
                    begin
                        pos_next   = pos_inc;
                        top_next   = ADDR_W'({pos_inc, 1'b0});
                        j_next     = '0;
                        state_next = S_PASS;
                    end
                    else
                    begin
                        ovf_next   = 1'b1;
                        state_next = item.last_position ? S_READ : S_IDLE;
                    end
                end
            end
            S_PASS:
            begin
                mac_ctl.issue = 1'b1;
                rd_en         = 1'b1;
                rd_addr       = j_reg;
                if (j_reg == top_reg)
                begin
                    drain_next = 1'b0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    j_next = j_reg + ADDR_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (drain_reg)
                begin
                    fill.set   = 1'b1;
                    state_next = last_reg ? S_READ : S_IDLE;
                end
                else
                begin
                    drain_next = 1'b1;
                end
            end
            S_READ:
            begin
                rd_addr = ADDR_W'(twice_pos - target_ext);
                if (ovf_reg)
                begin
                    status_next = STATUS_LONG;
                end
                else if (target_ext > twice_pos)
                begin
                    status_next = STATUS_TARGET;
                end
                else
                begin
                    status_next = STATUS_OK;
                    rd_en       = 1'b1;
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (load_out)
                begin
                    out_valid_next  = 1'b1;
                    out_count_next  = (status_reg == STATUS_OK) ? rd_data : '0;
                    out_status_next = status_reg;
                    pos_next        = '0;
                    ovf_next        = 1'b0;
                    fill.clear      = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg          <= j_next;
        top_reg        <= top_next;
        same_reg       <= same_next;
        last_reg       <= last_next;
        status_reg     <= status_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign fill_value         = FILL_W'(top_reg) + FILL_W'(1);
    assign item.ready         = state_reg == S_IDLE;
    assign result.valid       = out_valid_reg;
    assign result.point_count = out_count_reg;
    assign result.status      = out_status_reg;

    `HEPC_ASSERT_IMPLIES(a_pass_bound, clk, rst_n, state_reg == S_PASS, j_reg <= top_reg, "Pass index ran past the top of the table.")
    `HEPC_ASSERT_NEXT(a_overflow_set, clk, rst_n, item.valid && item.ready && (pos_reg == LEN_W'(MAX_LEN)), ovf_reg, "A word beyond the maximum length did not set the overflow flag.")
    `HEPC_ASSERT_NEXT(a_result_clears, clk, rst_n, load_out, (pos_reg == '0) && !ovf_reg && out_valid_reg && (state_reg == S_IDLE), "Delivering a result did not clear the word state.")

endmodule

>>> rtl/core/hamming_ellipse_point_count_unit.sv
`timescale 1ns / 1ps
// From acceptance to ready again, each position runs a pass over table entries 0 to 2*n, where
// n is the position count after it, one table entry per cycle through the shared multiply-add unit.
// After the last position, S_READ and S_RESULT read the count into the output register.
// The output register lets the next word start while a result waits to be taken.
// Reset is asynchronous and active low; it restores the configuration and control registers and an empty table.
module hamming_ellipse_point_count_unit
    import hepc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    hepc_in_if.sink           item,
    hepc_out_if.source        result
);

    localparam int ADDR_W = $clog2(2 * MAX_LEN + 1);
    localparam int FILL_W = $clog2(2 * MAX_LEN + 2);

    logic [Q_W-1:0]     alphabet_reg;
    logic [D_W-1:0]     target_reg;
    reg_index_t         reg_index;
    logic               cfg_write;

    mac_ctl_t           mac_ctl;
    fill_ctl_t          fill;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [COUNT_W-1:0] rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic [FILL_W-1:0]  fill_value;

    assign reg_index = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_reg <= ALPHABET_RESET;
            target_reg   <= TARGET_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_ALPHABET: alphabet_reg <= pwdata[Q_W-1:0];
                REG_TARGET:   target_reg   <= pwdata[D_W-1:0];
                default:      alphabet_reg <= alphabet_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_ALPHABET: prdata = APB_DW'(alphabet_reg);
            REG_TARGET:   prdata = APB_DW'(target_reg);
            default:      prdata = '0;
        endcase
    end

    hepc_ctrl #(
        .MAX_LEN(MAX_LEN)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .target     (target_reg),
        .mac_ctl    (mac_ctl),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .fill       (fill),
        .fill_value (fill_value)
    );

    hepc_mac #(
        .MAX_LEN(MAX_LEN)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .alphabet   (alphabet_reg),
        .mac_ctl    (mac_ctl),
        .issue_addr (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    hepc_table #(
        .MAX_LEN(MAX_LEN)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .fill       (fill),
        .fill_value (fill_value)
    );

endmodule

>>> dv/hepc_point_count_checker.sv
`timescale 1ns / 1ps
module hepc_point_count_checker
    import hepc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    hepc_in_if                item,
    hepc_out_if               result,
    output int                fail_count,
    output int                pending
);

    localparam int TABLE_LEN = 2 * MAX_LEN + 1;

    typedef struct packed {
        logic [COUNT_W-1:0] point_count;
        status_t            status;
    } ellipse_result_t;

    ellipse_result_t    expected_counts[$];
    logic [COUNT_W-1:0] match_table[TABLE_LEN];
    int                 positions;
    logic               overflowed;
    logic [Q_W-1:0]     alphabet;
    logic [D_W-1:0]     target;
    int                 mismatches = 0;

    task automatic clear_word();
        for (int j = 0; j < TABLE_LEN; j++)
        begin
            match_table[j] = '0;
        end
        match_table[0] = 64'd1;
        positions = 0;
        overflowed = 1'b0;
    endtask

    task automatic multiply_position(input logic same);
        logic [COUNT_W-1:0] q_wide;
        logic [COUNT_W-1:0] term;
        q_wide = {{(COUNT_W - Q_W){1'b0}}, alphabet};
        for (int j = 2 * positions; j >= 0; j--)
        begin
            if (same)
            begin
                term = (q_wide - 64'd1) * match_table[j];
                if (j >= 2)
                    term = term + match_table[j - 2];
            end
            else
            begin
                term = (q_wide - 64'd2) * match_table[j];
                if (j >= 1)
                    term = term + (match_table[j - 1] << 1);
            end
            match_table[j] = term;
        end
    endtask

    task automatic predict_position(input logic [SYM_W-1:0] a, input logic [SYM_W-1:0] b,
                                    input logic last);
        ellipse_result_t expect_word;
        int              idx;
        if (!overflowed)
        begin
            if (positions >= MAX_LEN)
                overflowed = 1'b1;
            else
            begin
                positions++;
                multiply_position(a == b);
            end
        end
        if (last)
        begin
            expect_word.point_count = '0;
            if (overflowed)
                expect_word.status = STATUS_LONG;
            else if (int'(target) > 2 * positions)
                expect_word.status = STATUS_TARGET;
            else
            begin
                idx = 2 * positions - int'(target);
                expect_word.status = STATUS_OK;
                if (idx < TABLE_LEN)
                    expect_word.point_count = match_table[idx];
            end
            expected_counts.push_back(expect_word);
            clear_word();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ellipse_result_t oldest;
        if (!rst_n)
        begin
            alphabet = ALPHABET_RESET;
            target = TARGET_RESET;
            clear_word();
            expected_counts.delete();
            pending <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_ALPHABET, 2'b00})
                    alphabet = pwdata[Q_W-1:0];
                else if (paddr == {REG_TARGET, 2'b00})
                    target = pwdata[D_W-1:0];
            end
            if (result.valid && result.ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word: expected none, actual count %0h status %0d",
                             $time, result.point_count, result.status);
                end
                else
                begin
                    oldest = expected_counts.pop_front();
                    if (result.point_count !== oldest.point_count)
                    begin
                        mismatches++;
                        $display("%0t: point_count mismatch: expected %0h, actual %0h",
                                 $time, oldest.point_count, result.point_count);
                    end
                    if (result.status !== oldest.status)
                    begin
                        mismatches++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, oldest.status, result.status);
                    end
                end
            end
            if (item.valid && item.ready)
                predict_position(item.sym_first, item.sym_second, item.last_position);
            pending <= expected_counts.size();
            fail_count <= mismatches;
        end
    end

endmodule

>>> dv/tb_hamming_ellipse_point_count_unit.sv
`timescale 1ns / 1ps
module tb_hamming_ellipse_point_count_unit;
    import hepc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 2 * MAX_LEN_DEFAULT + 16;
    localparam int RANDOM_ITEMS = 530;
    localparam int PHASE_ITEMS = 60;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              idling_on = 1'b1;
    int                cycle_count = 0;
    int                mismatch_count;
    int                expected_pending;

    hepc_in_if  item_ch ();
    hepc_out_if result_ch ();

    hamming_ellipse_point_count_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    hepc_point_count_checker #(
        .MAX_LEN (MAX_LEN_DEFAULT)
    ) u_point_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .item       (item_ch),
        .result     (result_ch),
        .fail_count (mismatch_count),
        .pending    (expected_pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_ch.ready <= !idling_on || ($urandom_range(99) >= 7);
    end

    task automatic write_register(input reg_index_t index, input logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (expected_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_shape(input int q, input int d);
        settle();
        write_register(REG_ALPHABET, APB_DW'(q));
        write_register(REG_TARGET, APB_DW'(d));
    endtask

    task automatic send_position(input logic [SYM_W-1:0] a, input logic [SYM_W-1:0] b,
                                 input logic last);
        int gap;
        gap = (idling_on && $urandom_range(99) < 7) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.sym_first <= a;
        item_ch.sym_second <= b;
        item_ch.last_position <= last;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    task automatic send_word(input int length);
        logic [SYM_W-1:0] a;
        logic [SYM_W-1:0] b;
        for (int p = 0; p < length; p++)
        begin
            a = SYM_W'($urandom_range(255));
            case ($urandom_range(3))
                0, 1: b = a;
                2: b = SYM_W'($urandom_range(255));
                default:
                begin
                    a = SYM_W'($urandom_range(3));
                    b = SYM_W'($urandom_range(3));
                end
            endcase
            send_position(a, b, p == length - 1);
        end
    endtask

    initial
    begin
        int items_sent;
        int phase_items;
        int word_len;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        item_ch.valid <= 1'b0;
        item_ch.sym_first <= '0;
        item_ch.sym_second <= '0;
        item_ch.last_position <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_position(8'd0, 8'd0, 1'b1);
        send_position(8'd255, 8'd0, 1'b1);
        send_position(8'd255, 8'd255, 1'b0);
        send_position(8'd0, 8'd255, 1'b1);
        send_position(8'hAA, 8'h55, 1'b0);
        send_position(8'd7, 8'd7, 1'b0);
        send_position(8'd128, 8'd127, 1'b1);
        item_ch.valid <= 1'b0;
        set_shape(256, 128);
        send_position(8'd3, 8'd3, 1'b0);
        send_position(8'd1, 8'd2, 1'b1);
        item_ch.valid <= 1'b0;
        set_shape(0, 1);
        send_position(8'd5, 8'd5, 1'b0);
        send_position(8'd5, 8'd6, 1'b1);
        item_ch.valid <= 1'b0;
        set_shape(1, 2);
        send_position(8'd0, 8'd1, 1'b0);
        send_position(8'd9, 8'd9, 1'b1);
        item_ch.valid <= 1'b0;

        items_sent = 0;
        for (int phase = 0; items_sent < RANDOM_ITEMS; phase++)
        begin
            case (phase)
                0: set_shape(2, 0);
                1: set_shape(256, 128);
                2: set_shape(0, 0);
                3: set_shape(1, 2);
                4: set_shape(511, 255);
                5: set_shape(3, 1);
                6: set_shape(4, 4);
                default: set_shape($urandom_range(2, 256), $urandom_range(0, 24));
            endcase
            idling_on = (phase != 3);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 5)
                    word_len = $urandom_range(62, 68);
                else
                    word_len = $urandom_range(1, 12);
                send_word(word_len);
                phase_items += word_len;
            end
            item_ch.valid <= 1'b0;
            items_sent += phase_items;
        end

        settle();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/hepc_pkg.sv
rtl/core/hepc_in_if.sv
rtl/core/hepc_out_if.sv
rtl/core/hepc_table.sv
rtl/core/hepc_mac.sv
rtl/core/hepc_ctrl.sv
rtl/core/hamming_ellipse_point_count_unit.sv
dv/hepc_point_count_checker.sv
dv/tb_hamming_ellipse_point_count_unit.sv
